// ----- rtl/sdp_pkg.sv -----
// Package for the int4 x int8 scaled dot product core.
// Widths, field offsets, defaults and the structs passed between stages.
// No dependencies.
package sdp_pkg;

    localparam int LANES_DEF      = 8;
    localparam int SCALE_BITS_DEF = 16;

    localparam int FIELD_LANES = 8;
    localparam int CODE_W      = 4;
    localparam int ACT_W       = 8;
    localparam int CODE_OFFSET = 8;
    localparam int PROD_W      = 12;
    localparam int ACC_W       = 32;
    localparam int SCALE_W     = 16;
    localparam int SC_PROD_W   = 2 * SCALE_W;
    localparam int FULL_W      = 64;
    localparam int SCALED_W    = 48;
    localparam int COUNT_W     = 4;

    localparam int CODES_LSB  = 0;
    localparam int ACTS_LSB   = CODES_LSB + FIELD_LANES * CODE_W;
    localparam int COUNT_LSB  = ACTS_LSB + FIELD_LANES * ACT_W;
    localparam int WSCALE_LSB = COUNT_LSB + COUNT_W;
    localparam int ASCALE_LSB = WSCALE_LSB + SCALE_W;
    localparam int S_DATA_W   = 136;
    localparam int M_DATA_W   = 80;

    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic [SCALE_W-1:0] w_scale;
        logic [SCALE_W-1:0] a_scale;
    } sdp_ctl_t;

    typedef struct packed {
        logic               valid;
        logic [ACC_W-1:0]   dot;
        logic [SCALE_W-1:0] w_scale;
        logic [SCALE_W-1:0] a_scale;
    } sdp_dot_t;

endpackage

// ----- rtl/sdp_lane.sv -----
// One multiply lane: int4 weight code (offset 8) times signed int8 activation.
// Registers the product, zero when the element is past the count. Uses sdp_pkg.
module sdp_lane (
    input  logic                       aclk,
    input  logic                       advance,
    input  logic                       en,
    input  logic [sdp_pkg::CODE_W-1:0] code,
    input  logic [sdp_pkg::ACT_W-1:0]  act,
    output sdp_pkg::prod_t             prod
);
    import sdp_pkg::*;

    logic signed [CODE_W:0] weight;
    prod_t                  prod_reg;
    prod_t                  prod_next;

    assign weight = $signed({1'b0, code}) - $signed((CODE_W+1)'(CODE_OFFSET));

    always_comb begin
        prod_next = '0;
        if (en) begin
            prod_next = PROD_W'(weight * $signed(act));
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/sdp_merge.sv -----
// Merge stage: sums the lane products into the wrapping 32-bit accumulator.
// Holds the beat's control alongside the lane registers. Uses sdp_pkg.
module sdp_merge #(
    parameter int NL = sdp_pkg::FIELD_LANES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  sdp_pkg::sdp_ctl_t ctl_in,
    input  sdp_pkg::prod_t    prod [NL],
    output sdp_pkg::sdp_dot_t dot_out
);
    import sdp_pkg::*;

    sdp_ctl_t         ctl_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] acc_sum;
    sdp_dot_t         dot_reg;
    sdp_dot_t         dot_next;

    always_comb begin
        acc_sum = acc_reg;
        for (int i = 0; i < NL; i++) begin
            acc_sum = acc_sum + {{(ACC_W-PROD_W){prod[i][PROD_W-1]}}, prod[i]};
        end
    end

    always_comb begin
        acc_next         = acc_reg;
        dot_next.valid   = 1'b0;
        dot_next.dot     = acc_sum;
        dot_next.w_scale = ctl_reg.w_scale;
        dot_next.a_scale = ctl_reg.a_scale;
        if (ctl_reg.valid) begin
            if (ctl_reg.last) begin
                acc_next       = '0;
                dot_next.valid = 1'b1;
            end else begin
                acc_next = acc_sum;
            end
        end
    end

    // only the valid bits and the accumulator are reset; data follows advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
            acc_reg       <= '0;
            dot_reg.valid <= 1'b0;
        end else if (advance) begin
            ctl_reg <= ctl_in;
            acc_reg <= acc_next;
            dot_reg <= dot_next;
        end
    end

    assign dot_out = dot_reg;

`ifndef ASSERT_OFF
    a_acc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && ctl_reg.valid && ctl_reg.last) |=> (acc_reg == '0))
        else $error("accumulator not cleared after last beat");
    a_acc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(acc_reg))
        else $error("accumulator moved during stall");
    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !(ctl_reg.valid && ctl_reg.last)) |=> !dot_reg.valid)
        else $error("result without a last beat");
`endif

endmodule

// ----- rtl/sdp_scale.sv -----
// Scaling stages: weight scale times activation scale, then dot times that into
// the product register, then an arithmetic shift right by SCALE_BITS. Uses sdp_pkg.
module sdp_scale #(
    parameter int SCALE_BITS = sdp_pkg::SCALE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  sdp_pkg::sdp_dot_t            dot_in,
    output logic                         out_valid,
    output logic [sdp_pkg::ACC_W-1:0]    raw_dot,
    output logic [sdp_pkg::SCALED_W-1:0] scaled_product
);
    import sdp_pkg::*;

    logic                        v3_reg;
    logic [ACC_W-1:0]            dot3_reg;
    logic [SC_PROD_W-1:0]        sc_reg;
    logic                        v4_reg;
    logic [ACC_W-1:0]            dot4_reg;
    logic signed [FULL_W-1:0]    full_reg;
    logic signed [FULL_W-1:0]    full_next;
    logic signed [FULL_W:0]      mul_wide;
    logic signed [FULL_W-1:0]    shifted;

    assign mul_wide  = $signed(dot3_reg) * $signed({1'b0, sc_reg});
    assign full_next = mul_wide[FULL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (advance) begin
            v3_reg <= dot_in.valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dot3_reg <= dot_in.dot;
            sc_reg   <= dot_in.w_scale * dot_in.a_scale;
            dot4_reg <= dot3_reg;
            full_reg <= full_next;
        end
    end

    assign shifted        = full_reg >>> SCALE_BITS;
    assign out_valid      = v4_reg;
    assign raw_dot        = dot4_reg;
    assign scaled_product = shifted[SCALED_W-1:0];

endmodule

// ----- rtl/int4_int8_scaled_dot_product_core.sv -----
// Top level of the int4 x int8 scaled dot product core.
// Instantiates the multiply lanes, the merge stage and the scaling stages.
// Depends on sdp_pkg, sdp_lane, sdp_merge and sdp_scale.
//
// Usage: each input beat on s_* carries eight 4-bit weight codes (weight is
// code minus 8), eight signed 8-bit activations, a valid element count and
// both Q0.16 scales. The products of the first count elements (capped at the
// lane count) are added to a wrapping 32-bit accumulator. A beat with s_tlast
// high closes the dot product: one result beat follows on m_* with the raw
// dot and the dot times both scales, shifted right by SCALE_BITS.
// Beats without s_tlast give no result.
// Pipeline: lane and control registers, merge result register, scaling registers.
// Throughput: one beat per cycle while not stalled, set by the accumulate in the
// merge stage; the lanes and the two multiply stages are pipelined.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds
// and s_tready is low; nothing is dropped.
// Reset: aresetn low empties the pipeline and clears the accumulator.
module int4_int8_scaled_dot_product_core #(
    parameter int LANES      = sdp_pkg::LANES_DEF,
    parameter int SCALE_BITS = sdp_pkg::SCALE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // weight_codes[31:0], activations[95:32], valid_count[99:96],
    // weight_scale[115:100], activation_scale[131:116], zero pad
    input  logic [sdp_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // raw_dot[31:0], scaled_product[79:32]
    output logic [sdp_pkg::M_DATA_W-1:0] m_tdata
);
    import sdp_pkg::*;

    localparam int NL = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;

    logic                advance;
    logic [COUNT_W-1:0]  count;
    sdp_ctl_t            ctl_in;
    prod_t               prod [NL];
    sdp_dot_t            dot;
    logic [ACC_W-1:0]    raw_dot;
    logic [SCALED_W-1:0] scaled_product;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign count    = s_tdata[COUNT_LSB +: COUNT_W];

    assign ctl_in.valid   = s_tvalid;
    assign ctl_in.last    = s_tlast;
    assign ctl_in.w_scale = s_tdata[WSCALE_LSB +: SCALE_W];
    assign ctl_in.a_scale = s_tdata[ASCALE_LSB +: SCALE_W];

    for (genvar i = 0; i < NL; i++) begin : g_lane
        sdp_lane u_lane (
            .aclk    (aclk),
            .advance (advance),
            .en      (count > COUNT_W'(i)),
            .code    (s_tdata[CODES_LSB + i*CODE_W +: CODE_W]),
            .act     (s_tdata[ACTS_LSB + i*ACT_W +: ACT_W]),
            .prod    (prod[i])
        );
    end

    sdp_merge #(
        .NL (NL)
    ) u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .ctl_in  (ctl_in),
        .prod    (prod),
        .dot_out (dot)
    );

    sdp_scale #(
        .SCALE_BITS (SCALE_BITS)
    ) u_scale (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .dot_in         (dot),
        .out_valid      (m_tvalid),
        .raw_dot        (raw_dot),
        .scaled_product (scaled_product)
    );

    assign m_tdata = {scaled_product, raw_dot};

endmodule
